// ===== src/mfb_pkg.sv =====
// Shared types and constants of the monochrome framebuffer blit block.
package mfb_pkg;

  localparam int ROW_BYTES   = 16;
  localparam int SCREEN_ROWS = 64;
  localparam int FRAME_BYTES = ROW_BYTES * SCREEN_ROWS;
  localparam int ADDR_W      = $clog2(FRAME_BYTES);
  localparam int SCREEN_COLS = ROW_BYTES * 8;

  // Bitmap geometry limits.
  localparam int MAX_WIDTH = 128;
  localparam int MAX_ROWS  = 64;

  typedef enum logic [1:0] {
    REQ_BLIT  = 2'd0,
    REQ_PIXEL = 2'd1,
    REQ_READ  = 2'd2,
    REQ_CLEAR = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    CFG_ORIGIN_X = 3'd0,
    CFG_ORIGIN_Y = 3'd1,
    CFG_WIDTH    = 3'd2,
    CFG_HEIGHT   = 3'd3,
    CFG_INVERT   = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD0,
    ST_MOD1
  } state_t;

  typedef struct packed {
    req_t       req_type;
    logic [7:0] bitmap_byte;
    logic [7:0] pixel_x;
    logic [7:0] pixel_y;
    logic       pixel_color;
    logic [9:0] read_address;
  } in_req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       blit_last;
  } out_res_t;

endpackage

// ===== src/mfb_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module mfb_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 1024,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/mono_framebuffer_bitmap_blit_core.sv =====
// Top level: monochrome framebuffer with pixel, read, clear and bitmap blit requests.
//
//  channel  | ports                              | handshake
//  ---------+------------------------------------+-------------------------------
//  request  | start, busy, in_req                | taken when start & !busy
//  result   | out_valid, out_res                 | one-cycle strobe, no backpressure
//  config   | cfg_valid, cfg_ready, cfg_index,   | written when cfg_valid & cfg_ready
//           | cfg_data                           |
//
// The frame store is one 1024x8 RAM with a registered read. A read or set pixel
// request passes through ST_MOD0 and a blit byte through ST_MOD0 and ST_MOD1 (a
// read-modify-write of the two framebuffer bytes it may straddle), before ST_IDLE.
// Reset and a clear request both sweep the RAM at one byte per cycle with busy high.
// A clear request's result goes out the cycle after the last write; reset gives none.
module mono_framebuffer_bitmap_blit_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  mfb_pkg::in_req_t  in_req,
  output logic            out_valid,
  output mfb_pkg::out_res_t out_res,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [2:0]      cfg_index,
  input  logic [7:0]      cfg_data
);
  import mfb_pkg::*;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [7:0] origin_x_r, origin_y_r, width_r;
  logic [6:0] height_r;
  logic       invert_r;

  // Bitmap cursor.
  logic [3:0] byte_column_r, byte_column_nxt;
  logic [5:0] row_count_r, row_count_nxt;
  logic       last_nxt;

  // Captured transaction.
  req_t              op_r;
  logic [ADDR_W-1:0] addr0_r, addr1_r;
  logic              ok0_r, ok1_r;
  logic [7:0]        mask0_r, data0_r, mask1_r, data1_r;
  logic              last_r;
  logic              clr_req_r;
  logic [ADDR_W-1:0] clr_cnt_r;

  logic [ADDR_W-1:0] addr0_nxt, addr1_nxt;
  logic              ok0_nxt, ok1_nxt;
  logic [7:0]        mask0_nxt, data0_nxt, mask1_nxt, data1_nxt;

  // RAM port signals.
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [7:0]        ram_wdata, ram_rdata;

  logic      out_valid_r, out_valid_nxt;
  out_res_t  out_res_r, out_res_nxt;

  logic accept;
  logic clr_done;

  // Blit geometry.
  logic [7:0] width_cap;
  logic [8:0] width_round;
  logic [4:0] cols;
  logic [6:0] rows;
  logic [8:0] blit_y;
  logic [7:0] blit_x0;
  logic [4:0] col0, col1;
  logic [2:0] shift;
  logic [7:0] pix;
  logic       row_ok;

  assign accept    = start && (state_r == ST_IDLE);
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign clr_done  = (clr_cnt_r == ADDR_W'(FRAME_BYTES - 1));

  always_comb begin
    width_cap   = (width_r > 8'(MAX_WIDTH)) ? 8'(MAX_WIDTH) : width_r;
    width_round = {1'b0, width_cap} + 9'd7;
    cols        = (width_round[7:3] == 5'd0) ? 5'd1 : width_round[7:3];
    if (height_r == 7'd0) begin
      rows = 7'd1;
    end else if (height_r > 7'(MAX_ROWS)) begin
      rows = 7'(MAX_ROWS);
    end else begin
      rows = height_r;
    end
    blit_y  = {1'b0, origin_y_r} + {3'b000, row_count_r};
    blit_x0 = origin_x_r + {1'b0, byte_column_r, 3'b000};
    col0    = blit_x0[7:3];
    col1    = col0 + 5'd1;
    shift   = blit_x0[2:0];
    pix     = in_req.bitmap_byte ^ {8{invert_r}};
    row_ok  = (32'(blit_y) < SCREEN_ROWS);
  end

  // Cursor advance for a blit byte.
  always_comb begin
    byte_column_nxt = byte_column_r;
    row_count_nxt   = row_count_r;
    last_nxt        = 1'b0;
    if ({1'b0, byte_column_r} + 5'd1 >= cols) begin
      byte_column_nxt = 4'd0;
      if ({1'b0, row_count_r} + 7'd1 >= rows) begin
        row_count_nxt = 6'd0;
        last_nxt      = 1'b1;
      end else begin
        row_count_nxt = row_count_r + 6'd1;
      end
    end else begin
      byte_column_nxt = byte_column_r + 4'd1;
    end
  end

  // Target bytes, masks and data for the transaction being accepted.
  always_comb begin
    addr0_nxt = '0;
    addr1_nxt = '0;
    ok0_nxt   = 1'b0;
    ok1_nxt   = 1'b0;
    mask0_nxt = 8'h00;
    data0_nxt = 8'h00;
    mask1_nxt = 8'h00;
    data1_nxt = 8'h00;
    unique case (in_req.req_type)
      REQ_BLIT: begin
        addr0_nxt = ADDR_W'(32'(blit_y) * ROW_BYTES) + ADDR_W'(col0);
        addr1_nxt = ADDR_W'(32'(blit_y) * ROW_BYTES) + ADDR_W'(col1);
        ok0_nxt   = row_ok && (32'(col0) < ROW_BYTES);
        // The second byte is touched only when the bitmap byte is unaligned.
        ok1_nxt   = row_ok && (32'(col1) < ROW_BYTES) && (shift != 3'd0);
        mask0_nxt = 8'hFF >> shift;
        data0_nxt = pix >> shift;
        mask1_nxt = ~mask0_nxt;
        data1_nxt = pix << (4'd8 - {1'b0, shift});
      end
      REQ_PIXEL: begin
        addr0_nxt = ADDR_W'(32'(in_req.pixel_y) * ROW_BYTES) + ADDR_W'(in_req.pixel_x[7:3]);
        ok0_nxt   = (32'(in_req.pixel_x) < SCREEN_COLS) && (32'(in_req.pixel_y) < SCREEN_ROWS);
        mask0_nxt = 8'h80 >> in_req.pixel_x[2:0];
        data0_nxt = {8{in_req.pixel_color}};
      end
      REQ_READ: begin
        addr0_nxt = ADDR_W'(in_req.read_address);
        ok0_nxt   = (32'(in_req.read_address) < FRAME_BYTES);
      end
      REQ_CLEAR: begin
        ok0_nxt = 1'b0;
      end
      default: begin
        ok0_nxt = 1'b0;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_nxt = (in_req.req_type == REQ_CLEAR) ? ST_CLEAR : ST_MOD0;
        end
      end
      ST_MOD0: begin
        state_nxt = (op_r == REQ_BLIT) ? ST_MOD1 : ST_IDLE;
      end
      ST_MOD1: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // RAM access and results.
  always_comb begin
    ram_we        = 1'b0;
    ram_waddr     = addr0_r;
    ram_wdata     = (ram_rdata & ~mask0_r) | (data0_r & mask0_r);
    ram_raddr     = addr0_nxt;
    out_valid_nxt = 1'b0;
    out_res_nxt   = '0;
    unique case (state_r)
      ST_CLEAR: begin
        ram_we        = 1'b1;
        ram_waddr     = clr_cnt_r;
        ram_wdata     = 8'h00;
        out_valid_nxt = clr_done && clr_req_r;
      end
      ST_IDLE: begin
        ram_raddr = addr0_nxt;
      end
      ST_MOD0: begin
        ram_raddr     = addr1_r;
        ram_we        = ok0_r && (op_r == REQ_BLIT || op_r == REQ_PIXEL);
        out_valid_nxt = (op_r != REQ_BLIT);
        if (op_r == REQ_READ && ok0_r) begin
          out_res_nxt.read_data = ram_rdata;
        end
      end
      ST_MOD1: begin
        ram_we                = ok1_r;
        ram_waddr             = addr1_r;
        ram_wdata             = (ram_rdata & ~mask1_r) | (data1_r & mask1_r);
        out_valid_nxt         = 1'b1;
        out_res_nxt.blit_last = last_r;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLEAR;
      clr_cnt_r     <= '0;
      clr_req_r     <= 1'b0;
      byte_column_r <= 4'd0;
      row_count_r   <= 6'd0;
      origin_x_r    <= 8'd0;
      origin_y_r    <= 8'd0;
      width_r       <= 8'd8;
      height_r      <= 7'd8;
      invert_r      <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (state_r == ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
        if (clr_done) begin
          clr_req_r <= 1'b0;
        end
      end
      if (accept) begin
        if (in_req.req_type == REQ_CLEAR) begin
          clr_cnt_r     <= '0;
          clr_req_r     <= 1'b1;
          byte_column_r <= 4'd0;
          row_count_r   <= 6'd0;
        end else if (in_req.req_type == REQ_BLIT) begin
          byte_column_r <= byte_column_nxt;
          row_count_r   <= row_count_nxt;
        end
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_ORIGIN_X: origin_x_r <= cfg_data;
          CFG_ORIGIN_Y: origin_y_r <= cfg_data;
          CFG_WIDTH:    width_r    <= cfg_data;
          CFG_HEIGHT:   height_r   <= cfg_data[6:0];
          CFG_INVERT:   invert_r   <= cfg_data[0];
          default: begin
          end
        endcase
      end
    end
  end

  // Transaction payload needs no reset.
  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
    if (accept) begin
      op_r    <= in_req.req_type;
      addr0_r <= addr0_nxt;
      addr1_r <= addr1_nxt;
      ok0_r   <= ok0_nxt;
      ok1_r   <= ok1_nxt;
      mask0_r <= mask0_nxt;
      data0_r <= data0_nxt;
      mask1_r <= mask1_nxt;
      data1_r <= data1_nxt;
      last_r  <= last_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  mfb_ram #(
    .WIDTH(8),
    .DEPTH(FRAME_BYTES)
  ) u_frame_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

endmodule
